[hdl/lprt_pkg.sv]
// Shared constants and types for the live-view packet reassembly tracker.
`default_nettype none

package lprt_pkg;

    localparam int IDX_W        = 11;
    localparam int PIC_LEN_BITS = 24;

    localparam logic [IDX_W-1:0] MAX_PACKET_BYTES = IDX_W'(1500);
    localparam logic [IDX_W-1:0] HEADER_BYTES     = IDX_W'(12);

    localparam logic [15:0] TYPE_FIRST  = 16'h9060;
    localparam logic [15:0] TYPE_MIDDLE = 16'h8060;
    localparam logic [15:0] TYPE_END    = 16'h80e0;

    localparam logic [7:0] MARK_HI = 8'hff;
    localparam logic [7:0] MARK_LO = 8'hd8;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_MIDDLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    localparam logic [1:0] ACT_DROP   = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_APPEND = 2'd2;

    localparam logic [PIC_LEN_BITS-1:0] PIC_MAX = '1;

    typedef struct packed {
        logic [1:0]              packet_kind;
        logic [1:0]              action;
        logic [IDX_W-1:0]        payload_start;
        logic [IDX_W-1:0]        payload_length;
        logic [31:0]             frame_id;
        logic [PIC_LEN_BITS-1:0] picture_bytes;
        logic                    picture_done;
    } t_desc;

endpackage

`default_nettype wire

[hdl/lprt_parse.sv]
// Input register, per-packet header parser and picture length tracking.
`default_nettype none

module lprt_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_of_packet,
    output logic               o_push,
    output lprt_pkg::t_desc    o_desc,
    input  wire logic          i_full
);
    import lprt_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;

    logic [IDX_W-1:0]        r_byte_index,       n_byte_index;
    logic [7:0]              r_previous_byte,    n_previous_byte;
    logic [15:0]             r_type_code_shift,  n_type_code_shift;
    logic [31:0]             r_packet_frame_shift, n_packet_frame_shift;
    logic                    r_marker_seen,      n_marker_seen;
    logic [IDX_W-1:0]        r_marker_offset,    n_marker_offset;
    logic [31:0]             r_picture_frame,    n_picture_frame;
    logic [PIC_LEN_BITS-1:0] r_picture_length,   n_picture_length;

    logic                    accept;
    logic                    consume;
    logic                    kept;
    logic [1:0]              kind;
    logic [IDX_W-1:0]        start;
    logic [IDX_W-1:0]        plen;
    logic [PIC_LEN_BITS:0]   sum;
    t_desc                   desc;

    assign consume = r_in_valid && (!r_in_last || !i_full);
    assign o_stall = r_in_valid && !consume;
    assign accept  = i_valid && !o_stall;

    // Per-byte header and marker tracking.
    always_comb begin
        kept                 = r_byte_index < MAX_PACKET_BYTES;
        n_byte_index         = r_byte_index;
        n_previous_byte      = r_previous_byte;
        n_type_code_shift    = r_type_code_shift;
        n_packet_frame_shift = r_packet_frame_shift;
        n_marker_seen        = r_marker_seen;
        n_marker_offset      = r_marker_offset;
        if (kept) begin
            if (r_byte_index < IDX_W'(2)) begin
                n_type_code_shift = {r_type_code_shift[7:0], r_in_byte};
            end else if (r_byte_index >= IDX_W'(4) && r_byte_index < IDX_W'(8)) begin
                n_packet_frame_shift = {r_packet_frame_shift[23:0], r_in_byte};
            end
            // Marker must start at offset 12 or later and end before the last byte.
            if (!r_marker_seen && r_byte_index >= HEADER_BYTES + IDX_W'(1) && !r_in_last
                    && (r_byte_index + IDX_W'(1)) < MAX_PACKET_BYTES
                    && r_previous_byte == MARK_HI && r_in_byte == MARK_LO) begin
                n_marker_seen   = 1'b1;
                n_marker_offset = r_byte_index - IDX_W'(1);
            end
            n_previous_byte = r_in_byte;
            n_byte_index    = r_byte_index + IDX_W'(1);
        end
    end

    // Descriptor for the packet ending with this byte.
    always_comb begin
        case (n_type_code_shift)
            TYPE_FIRST:  kind = KIND_FIRST;
            TYPE_MIDDLE: kind = KIND_MIDDLE;
            TYPE_END:    kind = KIND_END;
            default:     kind = KIND_BAD;
        endcase
        if (n_byte_index < HEADER_BYTES) begin
            kind = KIND_BAD;
        end

        n_picture_frame  = r_picture_frame;
        n_picture_length = r_picture_length;
        desc             = '0;
        start            = n_marker_seen ? n_marker_offset : HEADER_BYTES;
        plen             = n_byte_index - start;
        sum              = {1'b0, r_picture_length}
                         + {{(PIC_LEN_BITS + 1 - IDX_W){1'b0}}, n_byte_index - HEADER_BYTES};
        desc.packet_kind = kind;

        case (kind)
            KIND_FIRST: begin
                desc.action         = ACT_START;
                desc.payload_start  = start;
                desc.payload_length = plen;
                desc.frame_id       = n_packet_frame_shift;
                n_picture_frame     = n_packet_frame_shift;
                n_picture_length    = {{(PIC_LEN_BITS - IDX_W){1'b0}}, plen};
            end
            KIND_MIDDLE, KIND_END: begin
                desc.frame_id     = n_packet_frame_shift;
                desc.picture_done = (kind == KIND_END);
                if (n_packet_frame_shift == r_picture_frame) begin
                    desc.action         = ACT_APPEND;
                    desc.payload_start  = HEADER_BYTES;
                    desc.payload_length = n_byte_index - HEADER_BYTES;
                    n_picture_length    = sum[PIC_LEN_BITS] ? PIC_MAX
                                                            : sum[PIC_LEN_BITS-1:0];
                end
            end
            default: begin
                desc.action = ACT_DROP;
            end
        endcase
        desc.picture_bytes = n_picture_length;
    end

    assign o_push = consume && r_in_last;
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_of_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index         <= '0;
            r_previous_byte      <= '0;
            r_type_code_shift    <= '0;
            r_packet_frame_shift <= '0;
            r_marker_seen        <= 1'b0;
            r_marker_offset      <= '0;
            r_picture_frame      <= '0;
            r_picture_length     <= '0;
        end else if (consume) begin
            if (r_in_last) begin
                // Clear per-packet state after the descriptor.
                r_byte_index         <= '0;
                r_previous_byte      <= '0;
                r_type_code_shift    <= '0;
                r_packet_frame_shift <= '0;
                r_marker_seen        <= 1'b0;
                r_marker_offset      <= '0;
                r_picture_frame      <= n_picture_frame;
                r_picture_length     <= n_picture_length;
            end else begin
                r_byte_index         <= n_byte_index;
                r_previous_byte      <= n_previous_byte;
                r_type_code_shift    <= n_type_code_shift;
                r_packet_frame_shift <= n_packet_frame_shift;
                r_marker_seen        <= n_marker_seen;
                r_marker_offset      <= n_marker_offset;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/lprt_outq.sv]
// Descriptor output register with one skid entry.
`default_nettype none

module lprt_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lprt_pkg::t_desc i_desc,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output lprt_pkg::t_desc    o_desc
);
    import lprt_pkg::*;

    logic  r_out_valid;
    logic  r_skid_valid;
    t_desc r_out;
    t_desc r_skid;
    logic  pop;
    logic  load_out;

    assign pop      = r_out_valid && !i_stall;
    assign load_out = !r_out_valid || pop;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_desc   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : i_desc;
        end else if (i_push) begin
            r_skid <= i_desc;
        end
    end

endmodule

`default_nettype wire

[hdl/liveview_packet_reassembly_tracker.sv]
// Top level of the live-view packet reassembly tracker.
`default_nettype none

// Takes one datagram byte per transaction and, on the byte flagged as the last
// of its packet, delivers one descriptor: packet kind, action on the picture,
// kept payload offset and length, frame number, running picture length and the
// picture-done flag. A byte is taken every cycle unless o_stall is high, as on
// a last byte while the skid entry is full; the input register and the parser
// set that rate. A descriptor goes from the input register into the output
// register or the skid entry, which lets input flow while one waits on i_stall.
module liveview_packet_reassembly_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_of_packet,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_packet_kind,
    output logic [1:0]       o_action,
    output logic [10:0]      o_payload_start,
    output logic [10:0]      o_payload_length,
    output logic [31:0]      o_frame_id,
    output logic [23:0]      o_picture_bytes,
    output logic             o_picture_done
);
    import lprt_pkg::*;

    logic  push;
    logic  full;
    t_desc desc_in;
    t_desc desc_out;

    lprt_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_last_of_packet (i_last_of_packet),
        .o_push           (push),
        .o_desc           (desc_in),
        .i_full           (full)
    );

    lprt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc_in),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_desc  (desc_out)
    );

    assign o_packet_kind    = desc_out.packet_kind;
    assign o_action         = desc_out.action;
    assign o_payload_start  = desc_out.payload_start;
    assign o_payload_length = desc_out.payload_length;
    assign o_frame_id       = desc_out.frame_id;
    assign o_picture_bytes  = desc_out.picture_bytes;
    assign o_picture_done   = desc_out.picture_done;

endmodule

`default_nettype wire

[hdl/lprt_checker.sv]
// Port-level checks for the live-view packet reassembly tracker, with bind.
`default_nettype none

module lprt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_data_byte,
    input wire logic        i_last_of_packet,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_packet_kind,
    input wire logic [1:0]  o_action,
    input wire logic [10:0] o_payload_start,
    input wire logic [10:0] o_payload_length,
    input wire logic [31:0] o_frame_id,
    input wire logic [23:0] o_picture_bytes,
    input wire logic        o_picture_done
);
    import lprt_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte)
            && $stable(i_last_of_packet))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packet_kind) && $stable(o_action)
            && $stable(o_payload_start) && $stable(o_payload_length)
            && $stable(o_frame_id) && $stable(o_picture_bytes)
            && $stable(o_picture_done))
        else $error("descriptor changed while stalled");

    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_START |-> o_packet_kind == KIND_FIRST)
        else $error("picture start on a non-first packet");

    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_kind == KIND_BAD |-> o_action == ACT_DROP
            && o_payload_length == '0 && o_frame_id == '0 && !o_picture_done)
        else $error("bad packet descriptor not empty");

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_picture_done |-> o_packet_kind == KIND_END)
        else $error("picture done on a non-end packet");

endmodule

bind liveview_packet_reassembly_tracker lprt_checker u_lprt_checker (.*);

`default_nettype wire

[verif/liveview_packet_reassembly_tracker_tb.sv]
// Self-checking testbench for the live-view packet reassembly tracker.
`timescale 1ns / 100ps

module liveview_packet_reassembly_tracker_tb;
    import lprt_pkg::*;

    localparam int FILL_RAND = 0;    // random, never 0xff
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;
    localparam int FILL_ANY  = 3;    // random, any value

    localparam int PACE_NONE   = 0;
    localparam int PACE_FULL   = 1;
    localparam int PACE_SPARSE = 2;

    localparam int NO_MARK      = -1;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 400;
    localparam int N_ROWS       = 19;

    typedef struct {
        logic [15:0] code;
        logic [31:0] frame;
        int          len;
        int          mark;
        int          fill;
        bit          typed;
        t_desc       want;
    } t_pkt_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_of_packet = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_packet_kind;
    logic [1:0]  o_action;
    logic [10:0] o_payload_start;
    logic [10:0] o_payload_length;
    logic [31:0] o_frame_id;
    logic [23:0] o_picture_bytes;
    logic        o_picture_done;

    liveview_packet_reassembly_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_last_of_packet (i_last_of_packet),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packet_kind    (o_packet_kind),
        .o_action         (o_action),
        .o_payload_start  (o_payload_start),
        .o_payload_length (o_payload_length),
        .o_frame_id       (o_frame_id),
        .o_picture_bytes  (o_picture_bytes),
        .o_picture_done   (o_picture_done)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Tracker state mirrored by the predictor
    logic [10:0] pkt_count = '0;
    logic [7:0]  pkt_prev = '0;
    logic [15:0] pkt_code = '0;
    logic [31:0] pkt_frame = '0;
    logic        soi_seen = 1'b0;
    logic [10:0] soi_at = '0;
    logic [31:0] pic_frame = '0;
    logic [23:0] pic_len = '0;

    t_desc pending_desc[$];
    bit    use_typed = 1'b0;
    t_desc typed_want;
    int    fail_count = 0;
    int    bytes_sent = 0;
    int    send_pace = PACE_NONE;
    bit    hold_req = 1'b0;

    function automatic int draw_pause(input int pace);
        case (pace)
            PACE_FULL:   return $urandom_range(0, 16);
            PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:     return 0;
        endcase
    endfunction

    // Advance the tracker by one accepted byte; queue a descriptor on the last one.
    task automatic track_byte(input logic [7:0] b, input logic last);
        t_desc       d;
        int unsigned len;
        int unsigned sum;
        if (int'(pkt_count) < int'(MAX_PACKET_BYTES)) begin
            if (pkt_count < 2)
                pkt_code = {pkt_code[7:0], b};
            else if (pkt_count >= 4 && pkt_count < 8)
                pkt_frame = {pkt_frame[23:0], b};
            if (!soi_seen && int'(pkt_count) >= int'(HEADER_BYTES) + 1 && !last &&
                    int'(pkt_count) + 1 < int'(MAX_PACKET_BYTES) &&
                    pkt_prev == MARK_HI && b == MARK_LO) begin
                soi_seen = 1'b1;
                soi_at = pkt_count - 11'd1;
            end
            pkt_prev = b;
            pkt_count = pkt_count + 11'd1;
        end
        if (!last)
            return;

        d = '0;
        len = 32'(pkt_count);
        case (pkt_code)
            TYPE_FIRST:  d.packet_kind = KIND_FIRST;
            TYPE_MIDDLE: d.packet_kind = KIND_MIDDLE;
            TYPE_END:    d.packet_kind = KIND_END;
            default:     d.packet_kind = KIND_BAD;
        endcase
        if (len < HEADER_BYTES)
            d.packet_kind = KIND_BAD;

        if (d.packet_kind == KIND_FIRST) begin
            d.frame_id = pkt_frame;
            d.action = ACT_START;
            d.payload_start = soi_seen ? soi_at : HEADER_BYTES;
            d.payload_length = 11'(len) - d.payload_start;
            pic_frame = pkt_frame;
            pic_len = 24'(d.payload_length);
        end else if (d.packet_kind == KIND_MIDDLE || d.packet_kind == KIND_END) begin
            d.frame_id = pkt_frame;
            if (pkt_frame == pic_frame) begin
                d.action = ACT_APPEND;
                d.payload_start = HEADER_BYTES;
                d.payload_length = 11'(len) - HEADER_BYTES;
                sum = 32'(pic_len) + 32'(d.payload_length);
                pic_len = (sum > PIC_MAX) ? PIC_MAX : sum[23:0];
            end
            d.picture_done = (d.packet_kind == KIND_END);
        end
        d.picture_bytes = pic_len;
        pending_desc.push_back(use_typed ? typed_want : d);

        pkt_count = '0;
        pkt_prev = '0;
        pkt_code = '0;
        pkt_frame = '0;
        soi_seen = 1'b0;
        soi_at = '0;
    endtask

    // Entered and left at a falling edge.
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_pause(send_pace);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_of_packet <= last;
        do @(posedge i_clk); while (o_stall);
        track_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [15:0] code, input logic [31:0] frame,
                               input int len, input int mark, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                b = code[15:8];
            else if (i == 1)
                b = code[7:0];
            else if (i >= 4 && i < 8)
                b = frame[8*(7-i) +: 8];
            else if (mark != NO_MARK && i == mark)
                b = MARK_HI;
            else if (mark != NO_MARK && i == mark + 1)
                b = MARK_LO;
            else begin
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hff;
                    FILL_RAND: b = 8'($urandom_range(0, 254));
                    default:   b = 8'($urandom_range(0, 255));
                endcase
            end
            put_byte(b, i == len - 1);
        end
    endtask

    function automatic int body_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(12, 48);
        if (r < 19)
            return $urandom_range(49, 300);
        return $urandom_range(1, 11);
    endfunction

    function automatic int marker_spot(input int len);
        if (len > 13 && $urandom_range(0, 1) == 1)
            return $urandom_range(12, len - 1);
        return NO_MARK;
    endfunction

    function automatic logic [31:0] stray_frame(input logic [31:0] frame);
        if ($urandom_range(0, 9) == 0)
            return frame ^ (32'd1 << $urandom_range(0, 31));
        return frame;
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 2))
            0:       return TYPE_FIRST;
            1:       return TYPE_MIDDLE;
            default: return TYPE_END;
        endcase
    endfunction

    // One picture: first packet, up to four middles, then the end packet.
    task automatic send_picture();
        logic [31:0] frame;
        int          len;
        frame = $urandom;
        send_pace = $urandom_range(0, 2);
        len = body_len();
        send_packet(TYPE_FIRST, frame, len, marker_spot(len), FILL_ANY);
        repeat ($urandom_range(0, 4)) begin
            len = body_len();
            send_packet(TYPE_MIDDLE, stray_frame(frame), len, marker_spot(len), FILL_ANY);
        end
        send_packet(TYPE_END, stray_frame(frame), body_len(), NO_MARK, FILL_ANY);
    endtask

    task automatic send_noise();
        send_pace = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
            0: send_packet(pick_code(), $urandom, $urandom_range(1, 11), NO_MARK, FILL_ANY);
            1: send_packet(16'($urandom), $urandom, body_len(), NO_MARK, FILL_ANY);
            default: send_packet(($urandom_range(0, 1) == 1) ? TYPE_MIDDLE : TYPE_END,
                                 $urandom, body_len(), NO_MARK, FILL_ANY);
        endcase
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_desc want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_desc.size() == 0) begin
                $error("descriptor with none expected: kind %0d frame %h",
                       o_packet_kind, o_frame_id);
                fail_count++;
            end else begin
                want = pending_desc.pop_front();
                match_field("packet_kind", 32'(want.packet_kind), 32'(o_packet_kind));
                match_field("action", 32'(want.action), 32'(o_action));
                match_field("payload_start", 32'(want.payload_start),
                            32'(o_payload_start));
                match_field("payload_length", 32'(want.payload_length),
                            32'(o_payload_length));
                match_field("frame_id", want.frame_id, o_frame_id);
                match_field("picture_bytes", 32'(want.picture_bytes),
                            32'(o_picture_bytes));
                match_field("picture_done", 32'(want.picture_done), 32'(o_picture_done));
            end
        end
    end

    // Receiver: per-transaction stall, with a long hold-off on request.
    initial begin
        int hold;
        int pace;
        int left;
        pace = PACE_NONE;
        left = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (left == 0) begin
                pace = $urandom_range(0, 2);
                left = $urandom_range(5, 40);
            end
            left--;
            hold = draw_pause(pace);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        t_pkt_row plan [N_ROWS];
        int       start;
        bit       pressed;

        plan = '{
            '{TYPE_MIDDLE, 32'd0, 20, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_MIDDLE, ACT_APPEND, HEADER_BYTES, 11'd8, 32'd0, 24'd8, 1'b0}},
            '{TYPE_FIRST, 32'hffff_ffff, 12, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_FIRST, ACT_START, HEADER_BYTES, 11'd0, 32'hffff_ffff, 24'd0, 1'b0}},
            // overlong: only the first 1500 bytes count; marker too close to the limit
            '{TYPE_FIRST, 32'hffff_ffff, 1503, 1498, FILL_ONES, 1'b1,
              '{KIND_FIRST, ACT_START, HEADER_BYTES, 11'd1488, 32'hffff_ffff, 24'd1488,
                1'b0}},
            '{TYPE_FIRST, 32'd0, 11, NO_MARK, FILL_ZERO, 1'b1,
              '{KIND_BAD, ACT_DROP, 11'd0, 11'd0, 32'd0, 24'd1488, 1'b0}},
            '{16'hffff, 32'hffff_ffff, 30, NO_MARK, FILL_ONES, 1'b1,
              '{KIND_BAD, ACT_DROP, 11'd0, 11'd0, 32'd0, 24'd1488, 1'b0}},
            '{TYPE_FIRST, 32'd0, 1, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_BAD, ACT_DROP, 11'd0, 11'd0, 32'd0, 24'd1488, 1'b0}},
            '{16'h8061, 32'd7, 13, NO_MARK, FILL_ZERO, 1'b1,
              '{KIND_BAD, ACT_DROP, 11'd0, 11'd0, 32'd0, 24'd1488, 1'b0}},
            '{TYPE_FIRST, 32'd5, 30, 12, FILL_RAND, 1'b1,
              '{KIND_FIRST, ACT_START, HEADER_BYTES, 11'd18, 32'd5, 24'd18, 1'b0}},
            '{TYPE_FIRST, 32'd5, 40, 20, FILL_RAND, 1'b1,
              '{KIND_FIRST, ACT_START, 11'd20, 11'd20, 32'd5, 24'd20, 1'b0}},
            // marker low byte on the last byte does not count
            '{TYPE_FIRST, 32'd6, 16, 14, FILL_RAND, 1'b1,
              '{KIND_FIRST, ACT_START, HEADER_BYTES, 11'd4, 32'd6, 24'd4, 1'b0}},
            // marker starting inside the header does not count
            '{TYPE_FIRST, 32'd6, 20, 11, FILL_RAND, 1'b1,
              '{KIND_FIRST, ACT_START, HEADER_BYTES, 11'd8, 32'd6, 24'd8, 1'b0}},
            '{TYPE_MIDDLE, 32'd7, 25, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_MIDDLE, ACT_DROP, 11'd0, 11'd0, 32'd7, 24'd8, 1'b0}},
            '{TYPE_END, 32'd7, 12, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_END, ACT_DROP, 11'd0, 11'd0, 32'd7, 24'd8, 1'b1}},
            '{TYPE_MIDDLE, 32'd6, 12, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_MIDDLE, ACT_APPEND, HEADER_BYTES, 11'd0, 32'd6, 24'd8, 1'b0}},
            '{TYPE_MIDDLE, 32'd6, 50, 20, FILL_ZERO, 1'b1,
              '{KIND_MIDDLE, ACT_APPEND, HEADER_BYTES, 11'd38, 32'd6, 24'd46, 1'b0}},
            '{TYPE_END, 32'd6, 33, NO_MARK, FILL_RAND, 1'b1,
              '{KIND_END, ACT_APPEND, HEADER_BYTES, 11'd21, 32'd6, 24'd67, 1'b1}},
            // picture is kept after its end packet
            '{TYPE_MIDDLE, 32'd6, 14, NO_MARK, FILL_ZERO, 1'b1,
              '{KIND_MIDDLE, ACT_APPEND, HEADER_BYTES, 11'd2, 32'd6, 24'd69, 1'b0}},
            '{TYPE_FIRST, 32'h1357_9bdf, 47, 30, FILL_ANY, 1'b0, '0},
            '{TYPE_MIDDLE, 32'h1357_9bdf, 29, NO_MARK, FILL_ANY, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            send_pace = $urandom_range(0, 2);
            use_typed = plan[k].typed;
            typed_want = plan[k].want;
            send_packet(plan[k].code, plan[k].frame, plan[k].len, plan[k].mark, plan[k].fill);
        end
        use_typed = 1'b0;

        start = bytes_sent;
        pressed = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (!pressed && bytes_sent - start > 150) begin
                // hold the receiver and burst short packets to back up the input
                pressed = 1'b1;
                hold_req = 1'b1;
                send_pace = PACE_NONE;
                repeat (16)
                    send_packet(pick_code(), $urandom, $urandom_range(1, 3), NO_MARK, FILL_ANY);
            end else if ($urandom_range(0, 3) == 0) begin
                send_noise();
            end else begin
                send_picture();
            end
        end
        i_valid <= 1'b0;

        while (pending_desc.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
